@@ sv/square_tone_generator_macros.svh @@
`ifndef SQUARE_TONE_GENERATOR_MACROS_SVH
`define SQUARE_TONE_GENERATOR_MACROS_SVH

// check a condition at every clock edge out of reset
`define STG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check that a condition implies another in the same cycle
`define STG_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

@@ sv/stg_pkg.sv @@
package stg_pkg;

    localparam int LEN_W    = 16;
    localparam int FREQ_W   = 16;
    localparam int VOL_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 7;
    localparam int LEFT_W   = 22;
    localparam int PHASE_W  = 32;
    localparam int PERIOD_W = 16;
    localparam int HIGH_W   = 15;
    localparam int AMP_W    = 15;
    localparam int DIVS_W   = 16;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX     = 7'd100;
    localparam logic [LEVEL_W-1:0]  LEVEL_STEP    = 7'd5;
    localparam logic [LEVEL_W-1:0]  LEVEL_RESET   = 7'd50;
    localparam logic [AMP_W-1:0]    AMP_MAX       = 15'd32767;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 16'd65535;
    localparam logic [LEFT_W-1:0]   LEFT_MAX      = 22'd4194303;
    localparam logic [DIVS_W-1:0]   MS_PER_SECOND = 16'd1000;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_START    = 2'd1,
        OP_VOL_UP   = 2'd2,
        OP_VOL_DOWN = 2'd3
    } opcode_t;

endpackage

@@ sv/stg_divider.sv @@
module stg_divider #(
    parameter int DIVD_W = 33
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DIVD_W-1:0]           dividend,
    input  logic [stg_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [DIVD_W-1:0]           quotient,
    output logic [stg_pkg::DIVS_W-1:0]  remainder
);

    localparam int DW    = stg_pkg::DIVS_W;
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dvs_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = ~diff[DW+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/square_tone_generator.sv @@
// Square-wave tone generator, one signed sample per sample-tick beat.
// Input channel (in_valid/in_ready) carries opcode, duration_ms, frequency and
// volume; output channel (out_valid/out_ready) returns one beat per input
// beat with sample, playing and volume_level. cfg_we/cfg_wdata write the
// music enable bit at any edge with cfg_we high.
// Every division goes through one shared restoring divider that retires one
// quotient bit per cycle over a DIVD_W-bit dividend (32 bits at the default rate).
// Work done from input beat accepted to output beat offered:
//   volume step, idle tick, rejected start: no division
//   tick of a playing tone: one modulo division of the phase by the period (none at 0 Hz)
//   start tone: period division, then duration division (duration only at 0 Hz)
// in_ready is high only while the sequencer is idle; the next beat is taken
// as soon as a result sits in the output register, so one result can wait
// while the next item is worked on. A stalled receiver holds the result and
// parks the sequencer before it would overwrite it.
// Reset: music enabled, level 50, no tone loaded, phase 0, output empty.
module square_tone_generator #(
    parameter int SAMPLE_RATE = 32768
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [stg_pkg::LEN_W-1:0]           duration_ms,
    input  logic [stg_pkg::FREQ_W-1:0]          frequency,
    input  logic [stg_pkg::VOL_W-1:0]           volume,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [stg_pkg::SAMPLE_W-1:0] sample,
    output logic                                playing,
    output logic [stg_pkg::LEVEL_W-1:0]         volume_level,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata
);

`include "square_tone_generator_macros.svh"

    localparam int SR_W   = $clog2(SAMPLE_RATE + 1);
    localparam int PROD_W = stg_pkg::LEN_W + SR_W;
    localparam int DIVD_W = (PROD_W > stg_pkg::PHASE_W) ? PROD_W : stg_pkg::PHASE_W;
    localparam int AMPP_W = stg_pkg::VOL_W + stg_pkg::LEVEL_W;
    localparam int AMPX_W = AMPP_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DIV_PER = 5'b00010,
        ST_DIV_DUR = 5'b00100,
        ST_DIV_MOD = 5'b01000,
        ST_FIN     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                            music_enable_reg, music_enable_next;
    logic [stg_pkg::LEVEL_W-1:0]     user_level_reg, user_level_next;
    logic [stg_pkg::LEFT_W-1:0]      samples_left_reg, samples_left_next;
    logic [stg_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [stg_pkg::PERIOD_W-1:0]    period_reg, period_next;
    logic [stg_pkg::HIGH_W-1:0]      high_reg, high_next;
    logic [stg_pkg::AMP_W-1:0]       amp_reg, amp_next;
    logic [DIVD_W-1:0]               dur_prod_reg, dur_prod_next;
    logic [stg_pkg::SAMPLE_W-1:0]    sample_reg, sample_next;
    logic                            out_valid_reg, out_valid_next;
    logic [stg_pkg::SAMPLE_W-1:0]    out_sample_reg, out_sample_next;
    logic                            out_playing_reg, out_playing_next;
    logic [stg_pkg::LEVEL_W-1:0]     out_level_reg, out_level_next;

    logic                            div_start;
    logic [DIVD_W-1:0]               div_dividend;
    logic [stg_pkg::DIVS_W-1:0]      div_divisor;
    logic                            div_done;
    logic [DIVD_W-1:0]               div_quo;
    logic [stg_pkg::DIVS_W-1:0]      div_rem;

    logic [PROD_W-1:0]               len_prod;
    logic [AMPX_W-1:0]               amp_x2;
    logic [stg_pkg::AMP_W-1:0]       amp_sat;
    logic [stg_pkg::PERIOD_W-1:0]    per_sat;
    logic [stg_pkg::LEFT_W-1:0]      left_sat;
    logic [stg_pkg::LEVEL_W:0]       level_up;
    logic [stg_pkg::SAMPLE_W-1:0]    amp_pos;
    logic [stg_pkg::SAMPLE_W-1:0]    amp_neg;

    stg_divider #(
        .DIVD_W (DIVD_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        len_prod = duration_ms * SR_W'(SAMPLE_RATE);
        amp_x2   = {AMPP_W'(volume) * AMPP_W'(user_level_reg), 1'b0};
        amp_sat  = (amp_x2 > AMPX_W'(stg_pkg::AMP_MAX)) ? stg_pkg::AMP_MAX
                                                         : amp_x2[stg_pkg::AMP_W-1:0];
        per_sat  = (div_quo > DIVD_W'(stg_pkg::PERIOD_MAX)) ? stg_pkg::PERIOD_MAX
                                                             : div_quo[stg_pkg::PERIOD_W-1:0];
        left_sat = (div_quo > DIVD_W'(stg_pkg::LEFT_MAX)) ? stg_pkg::LEFT_MAX
                                                           : div_quo[stg_pkg::LEFT_W-1:0];
        level_up = {1'b0, user_level_reg} + {1'b0, stg_pkg::LEVEL_STEP};
        amp_pos  = {1'b0, amp_reg};
        amp_neg  = (~amp_pos) + stg_pkg::SAMPLE_W'(1);
    end

    always_comb
    begin
        state_next        = state_reg;
        music_enable_next = cfg_we ? cfg_wdata : music_enable_reg;
        user_level_next   = user_level_reg;
        samples_left_next = samples_left_reg;
        phase_next        = phase_reg;
        period_next       = period_reg;
        high_next         = high_reg;
        amp_next          = amp_reg;
        dur_prod_next     = dur_prod_reg;
        sample_next       = sample_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_sample_next   = out_sample_reg;
        out_playing_next  = out_playing_reg;
        out_level_next    = out_level_reg;
        div_start         = 1'b0;
        div_dividend      = '0;
        div_divisor       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = '0;
                    state_next  = ST_FIN;
                    case (opcode)
                        stg_pkg::OP_TICK:
                        begin
                            if (samples_left_reg != '0)
                            begin
                                if (period_reg == '0)
                                begin
                                    phase_next        = phase_reg + stg_pkg::PHASE_W'(1);
                                    samples_left_next = samples_left_reg - stg_pkg::LEFT_W'(1);
                                end
                                else
                                begin
                                    div_start    = 1'b1;
                                    div_dividend = DIVD_W'(phase_reg);
                                    div_divisor  = period_reg;
                                    state_next   = ST_DIV_MOD;
                                end
                            end
                        end
                        stg_pkg::OP_START:
                        begin
                            if (music_enable_reg)
                            begin
                                amp_next      = amp_sat;
                                dur_prod_next = DIVD_W'(len_prod);
                                div_start     = 1'b1;
                                if (frequency == '0)
                                begin
                                    period_next  = '0;
                                    high_next    = '0;
                                    div_dividend = DIVD_W'(len_prod);
                                    div_divisor  = stg_pkg::MS_PER_SECOND;
                                    state_next   = ST_DIV_DUR;
                                end
                                else
                                begin
                                    div_dividend = DIVD_W'(SAMPLE_RATE);
                                    div_divisor  = frequency;
                                    state_next   = ST_DIV_PER;
                                end
                            end
                        end
                        stg_pkg::OP_VOL_UP:
                        begin
                            user_level_next = (level_up > {1'b0, stg_pkg::LEVEL_MAX})
                                              ? stg_pkg::LEVEL_MAX
                                              : level_up[stg_pkg::LEVEL_W-1:0];
                        end
                        stg_pkg::OP_VOL_DOWN:
                        begin
                            user_level_next = (user_level_reg < stg_pkg::LEVEL_STEP)
                                              ? '0 : user_level_reg - stg_pkg::LEVEL_STEP;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV_PER:
            begin
                if (div_done)
                begin
                    period_next  = per_sat;
                    high_next    = per_sat[stg_pkg::PERIOD_W-1:1];
                    div_start    = 1'b1;
                    div_dividend = dur_prod_reg;
                    div_divisor  = stg_pkg::MS_PER_SECOND;
                    state_next   = ST_DIV_DUR;
                end
            end
            ST_DIV_DUR:
            begin
                if (div_done)
                begin
                    samples_left_next = left_sat;
                    state_next        = ST_FIN;
                end
            end
            ST_DIV_MOD:
            begin
                if (div_done)
                begin
                    sample_next       = (div_rem < {1'b0, high_reg}) ? amp_pos : amp_neg;
                    phase_next        = phase_reg + stg_pkg::PHASE_W'(1);
                    samples_left_next = samples_left_reg - stg_pkg::LEFT_W'(1);
                    state_next        = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_sample_next  = sample_reg;
                    out_playing_next = (samples_left_reg != '0);
                    out_level_next   = user_level_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            music_enable_reg <= 1'b1;
            user_level_reg   <= stg_pkg::LEVEL_RESET;
            samples_left_reg <= '0;
            phase_reg        <= '0;
            period_reg       <= '0;
            high_reg         <= '0;
            amp_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            music_enable_reg <= music_enable_next;
            user_level_reg   <= user_level_next;
            samples_left_reg <= samples_left_next;
            phase_reg        <= phase_next;
            period_reg       <= period_next;
            high_reg         <= high_next;
            amp_reg          <= amp_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_prod_reg    <= dur_prod_next;
        sample_reg      <= sample_next;
        out_sample_reg  <= out_sample_next;
        out_playing_reg <= out_playing_next;
        out_level_reg   <= out_level_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign sample       = $signed(out_sample_reg);
    assign playing      = out_playing_reg;
    assign volume_level = out_level_reg;

    `STG_ASSERT_ALWAYS(a_level_range, user_level_reg <= stg_pkg::LEVEL_MAX,
        "user level above maximum")
    `STG_ASSERT_ALWAYS(a_high_half, high_reg == period_reg[stg_pkg::PERIOD_W-1:1],
        "high half does not match period")
    `STG_ASSERT_IMPL(a_div_done_state, div_done,
        state_reg == ST_DIV_PER || state_reg == ST_DIV_DUR || state_reg == ST_DIV_MOD,
        "divider finished outside a divide state")

endmodule
